// ----- design/stmv_pkg.sv -----
// Shared types and constants for the sparse transposed mat-vec accumulator.
`default_nettype none

package stmv_pkg;

    localparam int ACTION_W = 2;
    localparam int X_W      = 16;
    localparam int COL_W    = 6;
    localparam int PROD_W   = 2 * X_W;
    localparam int SUM_W    = 40;
    localparam int NCOL_W   = 7;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);

    localparam logic [NCOL_W-1:0] NUM_COLS_RESET = 7'd64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ROW   = 2'd0,
        ACT_NZ    = 2'd1,
        ACT_DRAIN = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic {
        OP_ACCUM = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic [COL_W-1:0]          col;
        logic signed [PROD_W-1:0]  prod;
    } q_entry_t;

endpackage

`default_nettype wire

// ----- design/stmv_in_if.sv -----
// Input item channel: valid/ready with the item fields.
`default_nettype none

interface stmv_in_if;
    import stmv_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [ACTION_W-1:0]      action;
    logic signed [X_W-1:0]    row_x;
    logic signed [X_W-1:0]    entry_value;
    logic [COL_W-1:0]         column;

    modport source (output valid, output action, output row_x, output entry_value,
                    output column, input ready);
    modport sink   (input valid, input action, input row_x, input entry_value,
                    input column, output ready);
endinterface

`default_nettype wire

// ----- design/stmv_out_if.sv -----
// Result channel: valid/ready with column index, sum and last flag.
`default_nettype none

interface stmv_out_if;
    import stmv_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [COL_W-1:0]         column_index;
    logic signed [SUM_W-1:0]  column_sum;
    logic                     last;

    modport source (output valid, output column_index, output column_sum,
                    output last, input ready);
    modport sink   (input valid, input column_index, input column_sum,
                    input last, output ready);
endinterface

`default_nettype wire

// ----- design/sparse_transpose_matvec_accumulate.sv -----
// Top level of the streaming transposed sparse matrix-vector accumulator.
//
//   channel   direction  handshake       contents
//   items     in         valid/ready     action, row_x, entry_value, column
//   results   out        valid/ready     column_index, column_sum, last
//   cfg       in         cfg_we          cfg_wdata = num_cols
//
// Row starts only load the held x in the front end; outside a drain, nonzeros sustain
// one per cycle through the accumulator RAM (read, then saturating add and write with a
// one-entry bypass). A drain waits for the last write, then for each column reads the
// single RAM read port and, once the output register is free, emits it there.
// Reset clears the accumulators at once through per-column valid bits.
// A four-entry queue lets input and output stall independently.
`default_nettype none

module sparse_transpose_matvec_accumulate #(
    parameter int MAX_COLS = 64,
    parameter int ACC_BITS = 40
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    stmv_in_if.sink                          items,
    stmv_out_if.source                       results,
    input  wire logic                        cfg_we,
    input  wire logic [stmv_pkg::NCOL_W-1:0] cfg_wdata
);
    import stmv_pkg::*;

    logic [NCOL_W-1:0] num_cols_reg;
    logic [NCOL_W-1:0] n_cols;
    logic              q_full;
    logic              q_push;
    logic              q_avail;
    logic              q_pop;
    q_entry_t          q_push_entry;
    q_entry_t          q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= NUM_COLS_RESET;
        end
        else if (cfg_we)
        begin
            num_cols_reg <= cfg_wdata;
        end
    end

    // Zero acts as one column; anything past the store acts as the full store.
    always_comb
    begin
        if (num_cols_reg == '0)
        begin
            n_cols = NCOL_W'(1);
        end
        else if (num_cols_reg > NCOL_W'(MAX_COLS))
        begin
            n_cols = NCOL_W'(MAX_COLS);
        end
        else
        begin
            n_cols = num_cols_reg;
        end
    end

    stmv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .n_cols     (n_cols),
        .q_full     (q_full),
        .push       (q_push),
        .push_entry (q_push_entry)
    );

    stmv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .avail      (q_avail),
        .head       (q_head),
        .pop        (q_pop)
    );

    stmv_back #(
        .MAX_COLS (MAX_COLS),
        .ACC_BITS (ACC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .avail   (q_avail),
        .head    (q_head),
        .pop     (q_pop),
        .n_cols  (n_cols),
        .results (results)
    );

endmodule

`default_nettype wire

// ----- design/stmv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module stmv_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/stmv_front.sv -----
// Front end: accepts items, holds the row x element, forms products and queues work.
`default_nettype none

module stmv_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    stmv_in_if.sink                         items,
    input  wire logic [stmv_pkg::NCOL_W-1:0] n_cols,
    input  wire logic                       q_full,
    output logic                            push,
    output stmv_pkg::q_entry_t              push_entry
);
    import stmv_pkg::*;

    logic signed [X_W-1:0]    x_reg;
    logic signed [X_W-1:0]    x_next;
    logic signed [PROD_W-1:0] prod;
    logic                     accept;
    logic                     in_range;

    assign items.ready = !q_full;
    assign accept      = items.valid && items.ready;
    assign in_range    = {1'b0, items.column} < n_cols;
    assign prod        = items.entry_value * x_reg;

    always_comb
    begin
        x_next          = x_reg;
        push            = 1'b0;
        push_entry.op   = OP_ACCUM;
        push_entry.col  = items.column;
        push_entry.prod = prod;
        if (accept)
        begin
            case (action_t'(items.action))
                ACT_ROW:
                begin
                    x_next = items.row_x;
                end
                ACT_NZ:
                begin
                    // drop nonzeros beyond the active column count
                    push = in_range;
                end
                ACT_DRAIN:
                begin
                    push          = 1'b1;
                    push_entry.op = OP_DRAIN;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
        end
        else
        begin
            x_reg <= x_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/stmv_queue.sv -----
// Short work queue between the front end and the accumulate/drain back end.
`default_nettype none

module stmv_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire stmv_pkg::q_entry_t push_entry,
    output logic                    full,
    output logic                    avail,
    output stmv_pkg::q_entry_t      head,
    input  wire logic               pop
);
    import stmv_pkg::*;

    q_entry_t            entries_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = count_reg == (QPTR_W+1)'(QDEPTH);
    assign avail   = count_reg != '0;
    assign head    = entries_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && avail;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/stmv_back.sv -----
// Back end: accumulator read-modify-write with bypass, and the drain sequencer.
`default_nettype none

module stmv_back #(
    parameter int MAX_COLS = 64,
    parameter int ACC_BITS = 40
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        avail,
    input  wire stmv_pkg::q_entry_t          head,
    output logic                             pop,
    input  wire logic [stmv_pkg::NCOL_W-1:0] n_cols,
    stmv_out_if.source                       results
);
    import stmv_pkg::*;

    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DRD,
        ST_DEMIT
    } state_t;

    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
    localparam logic signed [64:0] SUM_MAX = (65'sd1 <<< (SUM_W-1)) - 65'sd1;
    localparam logic signed [64:0] SUM_MIN = -(65'sd1 <<< (SUM_W-1));

    state_t                    state_reg, state_next;
    logic [AW-1:0]             k_reg, k_next;
    logic [MAX_COLS-1:0]       vld_reg, vld_next;
    logic                      s2_vld_reg, s2_vld_next;
    logic [AW-1:0]             s2_col_reg, s2_col_next;
    logic signed [PROD_W-1:0]  s2_prod_reg, s2_prod_next;
    logic                      fwd_vld_reg;
    logic [AW-1:0]             fwd_col_reg;
    logic signed [ACC_BITS-1:0] fwd_data_reg;
    logic                      out_vld_reg, out_vld_next;
    logic [COL_W-1:0]          out_col_reg, out_col_next;
    logic signed [SUM_W-1:0]   out_sum_reg, out_sum_next;
    logic                      out_last_reg, out_last_next;

    logic                      re;
    logic [AW-1:0]             raddr;
    logic [ACC_BITS-1:0]       rdata;
    logic signed [ACC_BITS-1:0] acc_in;
    logic signed [ACC_BITS:0]  sum_wide;
    logic signed [ACC_BITS-1:0] sum_sat;
    logic signed [ACC_BITS-1:0] drain_acc;
    logic signed [64:0]        drain_wide;
    logic signed [SUM_W-1:0]   drain_sat;
    logic                      out_free;
    logic                      is_last;

    stmv_ram #(
        .WIDTH (ACC_BITS),
        .DEPTH (MAX_COLS),
        .AW    (AW)
    ) u_acc_ram (
        .clk   (clk),
        .we    (s2_vld_reg),
        .waddr (s2_col_reg),
        .wdata (sum_sat),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Bypass the write of the previous cycle: the RAM read saw stale data.
    always_comb
    begin
        if (fwd_vld_reg && (fwd_col_reg == s2_col_reg))
        begin
            acc_in = fwd_data_reg;
        end
        else if (vld_reg[s2_col_reg])
        begin
            acc_in = signed'(rdata);
        end
        else
        begin
            acc_in = '0;
        end
        sum_wide = (ACC_BITS+1)'(acc_in) + (ACC_BITS+1)'(s2_prod_reg);
        if (sum_wide[ACC_BITS] != sum_wide[ACC_BITS-1])
        begin
            sum_sat = sum_wide[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            sum_sat = sum_wide[ACC_BITS-1:0];
        end
    end

    // Clamp the drained accumulator to the result width.
    always_comb
    begin
        drain_acc  = vld_reg[k_reg] ? signed'(rdata) : '0;
        drain_wide = 65'(drain_acc);
        if (drain_wide > SUM_MAX)
        begin
            drain_sat = SUM_MAX[SUM_W-1:0];
        end
        else if (drain_wide < SUM_MIN)
        begin
            drain_sat = SUM_MIN[SUM_W-1:0];
        end
        else
        begin
            drain_sat = drain_wide[SUM_W-1:0];
        end
    end

    assign out_free = !out_vld_reg || results.ready;
    assign is_last  = (NCOL_W'(k_reg) + 1'b1) == n_cols;

    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        vld_next      = vld_reg;
        pop           = 1'b0;
        re            = 1'b0;
        raddr         = head.col[AW-1:0];
        s2_vld_next   = 1'b0;
        s2_col_next   = head.col[AW-1:0];
        s2_prod_next  = head.prod;
        out_vld_next  = out_vld_reg && !results.ready;
        out_col_next  = out_col_reg;
        out_sum_next  = out_sum_reg;
        out_last_next = out_last_reg;
        if (s2_vld_reg)
        begin
            vld_next[s2_col_reg] = 1'b1;
        end
        case (state_reg)
            ST_RUN:
            begin
                if (avail)
                begin
                    if (head.op == OP_ACCUM)
                    begin
                        pop         = 1'b1;
                        re          = 1'b1;
                        s2_vld_next = 1'b1;
                    end
                    else if (!s2_vld_reg)
                    begin
                        // drain only once the last write has landed
                        pop        = 1'b1;
                        k_next     = '0;
                        state_next = ST_DRD;
                    end
                end
            end
            ST_DRD:
            begin
                re         = 1'b1;
                raddr      = k_reg;
                state_next = ST_DEMIT;
            end
            ST_DEMIT:
            begin
                if (out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_col_next    = COL_W'(k_reg);
                    out_sum_next    = drain_sat;
                    out_last_next   = is_last;
                    vld_next[k_reg] = 1'b0;
                    if (is_last)
                    begin
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_DRD;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_RUN;
            k_reg       <= '0;
            vld_reg     <= '0;
            s2_vld_reg  <= 1'b0;
            fwd_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            vld_reg     <= vld_next;
            s2_vld_reg  <= s2_vld_next;
            fwd_vld_reg <= s2_vld_reg;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_col_reg   <= s2_col_next;
        s2_prod_reg  <= s2_prod_next;
        fwd_col_reg  <= s2_col_reg;
        fwd_data_reg <= sum_sat;
        out_col_reg  <= out_col_next;
        out_sum_reg  <= out_sum_next;
        out_last_reg <= out_last_next;
    end

    assign results.valid        = out_vld_reg;
    assign results.column_index = out_col_reg;
    assign results.column_sum   = out_sum_reg;
    assign results.last         = out_last_reg;

endmodule

`default_nettype wire

// ----- dv/stmv_sum_checker.sv -----
// Column-sum predictor and result scoring for the sparse transposed mat-vec accumulator.
module stmv_sum_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    stmv_in_if                          items,
    stmv_out_if                         results,
    input  logic                        cfg_we,
    input  logic [stmv_pkg::NCOL_W-1:0] cfg_wdata,
    output int                          fail_count,
    output int                          pending,
    output int                          sums_checked,
    output int                          sums_clipped
);
    timeunit 1ns;
    timeprecision 1ps;
    import stmv_pkg::*;

    localparam int     MAX_COLS = 64;
    localparam longint SUM_HI   = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
    localparam longint SUM_LO   = -SUM_HI - 64'sd1;

    typedef struct {
        logic [COL_W-1:0]        col;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } col_total_t;

    longint                col_acc [MAX_COLS];
    logic signed [X_W-1:0] held_x;
    logic [NCOL_W-1:0]     num_cols;
    col_total_t            expected_totals [$];

    function automatic int active_cols(logic [NCOL_W-1:0] n);
        if (n == 0)
            return 1;
        if (n > MAX_COLS)
            return MAX_COLS;
        return int'(n);
    endfunction

    function automatic longint clip_add(longint acc, longint prod);
        longint s;
        s = acc + prod;
        if (s > SUM_HI)
            return SUM_HI;
        if (s < SUM_LO)
            return SUM_LO;
        return s;
    endfunction

    task automatic fold_item(logic [ACTION_W-1:0] act, logic signed [X_W-1:0] x,
                             logic signed [X_W-1:0] v, logic [COL_W-1:0] col);
        int         n;
        col_total_t t;
        n = active_cols(num_cols);
        case (act)
            ACT_ROW:
                held_x = x;
            ACT_NZ:
                // drop nonzeros that fall past the active column count
                if (int'(col) < n)
                    col_acc[col] = clip_add(col_acc[col], longint'(v) * longint'(held_x));
            ACT_DRAIN:
                for (int k = 0; k < n; k++)
                begin
                    t.col  = COL_W'(k);
                    t.sum  = SUM_W'(col_acc[k]);
                    t.last = (k == n - 1);
                    expected_totals.push_back(t);
                    col_acc[k] = 0;
                end
            default:
                ;
        endcase
    endtask

    task automatic check_total(logic [COL_W-1:0] col, logic signed [SUM_W-1:0] sum,
                               logic last);
        col_total_t t;
        if (expected_totals.size() == 0)
        begin
            if (fail_count < 10)
                $display("unexpected column sum: col %0d sum %0d last %0b", col, sum, last);
            fail_count++;
            return;
        end
        t = expected_totals.pop_front();
        sums_checked++;
        if (longint'(t.sum) == SUM_HI || longint'(t.sum) == SUM_LO)
            sums_clipped++;
        if (col !== t.col || sum !== t.sum || last !== t.last)
        begin
            if (fail_count < 10)
                $display("column sum mismatch: expected col %0d sum %0d last %0b,",
                         t.col, t.sum, t.last,
                         " got col %0d sum %0d last %0b", col, sum, last);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_COLS; k++)
                col_acc[k] = 0;
            held_x   = '0;
            num_cols = NUM_COLS_RESET;
            expected_totals.delete();
            fail_count   = 0;
            pending      = 0;
            sums_checked = 0;
            sums_clipped = 0;
        end
        else
        begin
            if (cfg_we)
                num_cols = cfg_wdata;
            if (results.valid && results.ready)
                check_total(results.column_index, results.column_sum, results.last);
            if (items.valid && items.ready)
                fold_item(items.action, items.row_x, items.entry_value, items.column);
            pending = expected_totals.size();
        end
    end
endmodule

// ----- dv/sparse_transpose_matvec_accumulate_tb.sv -----
// Stimulus, reset, clocking and verdict for the sparse transposed mat-vec accumulator.
module sparse_transpose_matvec_accumulate_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import stmv_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [NCOL_W-1:0] cfg_wdata;

    int                fail_count;
    int                pending;
    int                sums_checked;
    int                sums_clipped;

    bit                quiet    = 1'b0;
    bit                hold_req = 1'b0;
    int                items_sent;
    int                settings_used;
    logic [NCOL_W-1:0] cur_cols = NUM_COLS_RESET;

    stmv_in_if  items ();
    stmv_out_if results ();

    sparse_transpose_matvec_accumulate uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .results   (results),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    stmv_sum_checker sum_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .items        (items),
        .results      (results),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .sums_checked (sums_checked),
        .sums_clipped (sums_clipped)
    );

    always #10 clk = ~clk;

    function automatic int eff_cols();
        if (cur_cols == 0)
            return 1;
        if (cur_cols > 64)
            return 64;
        return int'(cur_cols);
    endfunction

    function automatic logic [X_W-1:0] pick_q15();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return X_W'($urandom_range(0, 15)) - 16'd8;
            default: return X_W'($urandom);
        endcase
    endfunction

    function automatic logic [COL_W-1:0] pick_col(int n);
        if ($urandom_range(0, 7) == 0)
            return COL_W'($urandom_range(0, 63));
        return COL_W'($urandom_range(0, n - 1));
    endfunction

    // Offer one item and return at the edge where it transfers.
    task automatic send(action_t act, logic [X_W-1:0] x, logic [X_W-1:0] v,
                        logic [COL_W-1:0] col);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 12);
            items.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items.valid       <= 1'b1;
        items.action      <= act;
        items.row_x       <= x;
        items.entry_value <= v;
        items.column      <= col;
        do @(negedge clk); while (!items.ready);
        @(posedge clk);
        if (act != ACT_NONE && !(act == ACT_NZ && int'(col) >= eff_cols()))
            items_sent++;
    endtask

    // Hold the sender until every column sum is back and the pipe has drained.
    task automatic settle();
        items.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (24) @(posedge clk);
    endtask

    task automatic write_cols(logic [NCOL_W-1:0] n);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_cols = n;
        settings_used++;
    endtask

    task automatic random_phase(int budget);
        int start;
        int n;
        int k;
        start = items_sent;
        n = eff_cols();
        while (items_sent - start < budget)
        begin
            case ($urandom_range(0, 9))
                0: send(ACT_NONE, X_W'($urandom), X_W'($urandom), COL_W'($urandom));
                1: send(ACT_NZ, X_W'($urandom), pick_q15(), COL_W'($urandom_range(0, 63)));
                2: send(ACT_DRAIN, X_W'($urandom), X_W'($urandom), COL_W'($urandom));
                default:
                begin
                    send(ACT_ROW, pick_q15(), X_W'($urandom), COL_W'($urandom));
                    k = $urandom_range(1, 6);
                    repeat (k) send(ACT_NZ, X_W'($urandom), pick_q15(), pick_col(n));
                    if ($urandom_range(0, 3) == 0)
                        send(ACT_DRAIN, X_W'($urandom), X_W'($urandom), COL_W'($urandom));
                end
            endcase
        end
        send(ACT_DRAIN, X_W'($urandom), X_W'($urandom), COL_W'($urandom));
    endtask

    // Result-side ready: random bursts, a long hold on request, none when quiet.
    initial
    begin
        results.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                results.ready <= 1'b0;
                for (int c = 0; c < 180; c++)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                results.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                results.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    initial
    begin
        #40ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [NCOL_W-1:0] plan [8];
        rst_n = 1'b0;
        items.valid       <= 1'b0;
        items.action      <= ACT_NONE;
        items.row_x       <= '0;
        items.entry_value <= '0;
        items.column      <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: nonzero with x still zero, unused action, operand extremes,
        // back-to-back hits on one column, edge columns, drain of an empty store.
        send(ACT_NZ,    16'h1234, 16'h7fff, 6'd5);
        send(ACT_NONE,  16'hffff, 16'hffff, 6'h3f);
        send(ACT_ROW,   16'h8000, 16'h0000, 6'd0);
        send(ACT_NZ,    16'h0000, 16'h8000, 6'd0);
        send(ACT_NZ,    16'h0000, 16'h8000, 6'd0);
        send(ACT_NZ,    16'hffff, 16'h7fff, 6'd63);
        send(ACT_ROW,   16'h7fff, 16'hffff, 6'h3f);
        send(ACT_NZ,    16'h0000, 16'h8000, 6'd63);
        send(ACT_NZ,    16'h0000, 16'h7fff, 6'd63);
        send(ACT_ROW,   16'hffff, 16'h0000, 6'd0);
        send(ACT_NZ,    16'h0000, 16'h0001, 6'd1);
        send(ACT_NZ,    16'h0000, 16'h0000, 6'd2);
        send(ACT_DRAIN, 16'h0000, 16'h0000, 6'd0);
        send(ACT_DRAIN, 16'hffff, 16'hffff, 6'h3f);
        send(ACT_NONE,  16'h0000, 16'h0000, 6'd0);

        // Single column, then the out-of-range register codes.
        write_cols(7'd1);
        send(ACT_NZ,    16'h0000, 16'h7fff, 6'd0);
        send(ACT_NZ,    16'h0000, 16'h7fff, 6'd1);
        send(ACT_NZ,    16'h0000, 16'h7fff, 6'd63);
        send(ACT_DRAIN, 16'h0000, 16'h0000, 6'd0);
        write_cols(7'd0);
        send(ACT_ROW,   16'd12345, 16'h0000, 6'd0);
        send(ACT_NZ,    16'h0000, 16'h8000, 6'd0);
        send(ACT_NZ,    16'h0000, 16'h8000, 6'd1);
        send(ACT_DRAIN, 16'h0000, 16'h0000, 6'd0);
        write_cols(7'd127);
        send(ACT_DRAIN, 16'h0000, 16'h0000, 6'd0);

        // Long result hold while drains keep coming: fill the block until it stalls input.
        write_cols(7'd64);
        hold_req = 1'b1;
        send(ACT_ROW, pick_q15(), X_W'($urandom), COL_W'($urandom));
        repeat (3)
        begin
            repeat (3) send(ACT_NZ, X_W'($urandom), pick_q15(), COL_W'($urandom));
            send(ACT_DRAIN, X_W'($urandom), X_W'($urandom), COL_W'($urandom));
        end

        plan = '{7'd64, 7'd1, 7'd13, NCOL_W'($urandom_range(1, 64)),
                 7'd100, 7'd0, 7'd127, 7'd40};
        for (int p = 0; p < 8; p++)
        begin
            write_cols(plan[p]);
            if (p >= 6)
                quiet = 1'b1;
            random_phase(32);
        end
        settle();

        $display("covered %0d counted items across %0d column-count settings",
                 items_sent, settings_used);
        $display("checked %0d column sums, %0d of them at a saturation limit",
                 sums_checked, sums_clipped);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ----- filelist.f -----
design/stmv_pkg.sv
design/stmv_in_if.sv
design/stmv_out_if.sv
design/stmv_ram.sv
design/stmv_front.sv
design/stmv_queue.sv
design/stmv_back.sv
design/sparse_transpose_matvec_accumulate.sv
dv/stmv_sum_checker.sv
dv/sparse_transpose_matvec_accumulate_tb.sv
